// ===== rtl/rbwa_pkg.sv =====
// Shared types and constants for the ring buffer with window average.
// No dependencies; every other file in this folder but rbwa_ram imports this package.
package rbwa_pkg;

    localparam int DEF_MAX_DEPTH = 1024;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 11;
    localparam int OP_W          = 2;
    localparam int USED_W        = 10;
    localparam int AVG_W         = 40;
    localparam int FRAC_W        = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_PUSH  = 2'd1,
        OP_GET   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear;
        logic exec;
        logic div_load;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
    } t_status;

endpackage

// ===== rtl/rbwa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rbwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rbwa_ctrl.sv =====
// Controller state machine: clearing sweep, operation execute, divide, result strobe.
// Depends on rbwa_pkg; drives the datapath through t_cmd and reads t_status.
module rbwa_ctrl import rbwa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  logic            i_cfg_we,
    input  t_status         i_status,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    t_state r_state, n_state;
    logic   r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = r_reply ? S_DIV : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (t_op'(i_op) == OP_CLEAR) begin
                        n_state = S_CLEAR;
                        n_reply = 1'b1;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_CLEAR;
            n_reply = 1'b0;
        end
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear    = 1'b1;
                o_cmd.div_load = i_status.clr_last && r_reply;
            end
            S_IDLE: begin
                o_cmd.accept = i_start;
            end
            S_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.div_load = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.finish   = i_status.div_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/rbwa_dp.sv =====
// Datapath: size register, ring pointers, running sum, sample RAM and bit-serial divider.
// Depends on rbwa_pkg and rbwa_ram; commanded by rbwa_ctrl through t_cmd.
module rbwa_dp import rbwa_pkg::*; #(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_write_value,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_buffer_size,
    output logic              o_done,
    output logic [DATA_W-1:0] o_read_value,
    output logic              o_read_ok,
    output logic [USED_W-1:0] o_used_count,
    output logic [AVG_W-1:0]  o_average
);

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int SW   = $clog2(MAX_DEPTH + 1);
    localparam int SUMW = DATA_W + AW;
    localparam int DW   = SUMW + FRAC_W;
    localparam int CW   = $clog2(DW);

    logic [SW-1:0]     r_size, n_size;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic [AW-1:0]     r_clr_cnt, n_clr_cnt;
    t_op               r_op, n_op;
    logic [DATA_W-1:0] r_wv, n_wv;
    logic [DATA_W-1:0] r_rd_value, n_rd_value;
    logic              r_rd_ok, n_rd_ok;
    logic [SW-1:0]     r_used, n_used;
    logic              r_done, n_done;
    logic [SW-1:0]     r_rem, n_rem;
    logic [DW-1:0]     r_quo, n_quo;
    logic [CW-1:0]     r_div_cnt, n_div_cnt;

    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;

    logic [31:0]       cfg_raw;
    logic [SW-1:0]     size_clamped;
    logic [AW-1:0]     head_nx, tail_nx1, tail_nx2;
    logic [SW:0]       shifted;
    logic [SW-1:0]     occupancy;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p,
                                                input logic [SW-1:0] size);
        logic [SW:0] q;
        q = (SW+1)'(p) + (SW+1)'(1);
        next_slot = (q >= (SW+1)'(size)) ? '0 : q[AW-1:0];
    endfunction

    rbwa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = (t_op'(i_op) == OP_GET) ? r_tail : r_head;
    assign ram_we    = i_cmd.clear || (i_cmd.exec && (r_op inside {OP_PUT, OP_PUSH}));
    assign ram_waddr = i_cmd.clear ? r_clr_cnt : r_head;
    assign ram_wdata = i_cmd.clear ? '0 : r_wv;

    assign cfg_raw      = 32'(i_buffer_size);
    assign size_clamped = (cfg_raw < 32'd2) ? SW'(2) :
                          (cfg_raw > 32'(MAX_DEPTH)) ? SW'(MAX_DEPTH) : SW'(cfg_raw);

    assign head_nx  = next_slot(r_head, r_size);
    assign tail_nx1 = next_slot(r_tail, r_size);
    assign tail_nx2 = next_slot(tail_nx1, r_size);

    assign occupancy = (r_head >= r_tail) ? SW'(r_head) - SW'(r_tail)
                                          : r_size - SW'(r_tail) + SW'(r_head);
    assign shifted   = {r_rem, r_quo[DW-1]};

    assign o_status.clr_last = (SW'(r_clr_cnt) == r_size - SW'(1));
    assign o_status.div_last = (r_div_cnt == CW'(DW - 1));

    always_comb begin
        n_size     = r_size;
        n_head     = r_head;
        n_tail     = r_tail;
        n_sum      = r_sum;
        n_clr_cnt  = r_clr_cnt;
        n_op       = r_op;
        n_wv       = r_wv;
        n_rd_value = r_rd_value;
        n_rd_ok    = r_rd_ok;
        n_used     = r_used;
        n_done     = i_cmd.finish;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_div_cnt  = r_div_cnt;

        if (i_cfg_we) begin
            n_size    = size_clamped;
            n_head    = '0;
            n_tail    = '0;
            n_sum     = '0;
            n_clr_cnt = '0;
        end else begin
            if (i_cmd.accept) begin
                n_op       = t_op'(i_op);
                n_wv       = i_write_value;
                n_rd_value = '0;
                n_rd_ok    = 1'b0;
                if (t_op'(i_op) == OP_CLEAR) begin
                    n_head    = '0;
                    n_tail    = '0;
                    n_sum     = '0;
                    n_clr_cnt = '0;
                end
            end
            if (i_cmd.clear) begin
                n_clr_cnt = r_clr_cnt + AW'(1);
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_PUT, OP_PUSH: begin
                        n_sum  = r_sum - SUMW'(ram_rdata) + SUMW'(r_wv);
                        n_head = head_nx;
                        if (head_nx == r_tail) begin
                            n_tail = (r_op == OP_PUSH) ? tail_nx2 : tail_nx1;
                        end else begin
                            n_tail = (r_op == OP_PUSH) ? tail_nx1 : r_tail;
                        end
                    end
                    OP_GET: begin
                        if (r_head != r_tail) begin
                            n_rd_value = ram_rdata;
                            n_rd_ok    = 1'b1;
                            n_tail     = tail_nx1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_cmd.div_load) begin
            n_quo     = {n_sum, {FRAC_W{1'b0}}};
            n_rem     = '0;
            n_div_cnt = '0;
        end else if (i_cmd.div_step) begin
            if (shifted >= {1'b0, r_size}) begin
                n_rem = SW'(shifted - {1'b0, r_size});
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = shifted[SW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_div_cnt = r_div_cnt + CW'(1);
        end

        if (i_cmd.finish) begin
            n_used = occupancy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SW'(MAX_DEPTH);
            r_head    <= '0;
            r_tail    <= '0;
            r_sum     <= '0;
            r_clr_cnt <= '0;
            r_rd_ok   <= 1'b0;
            r_done    <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            r_size    <= n_size;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_sum     <= n_sum;
            r_clr_cnt <= n_clr_cnt;
            r_rd_ok   <= n_rd_ok;
            r_done    <= n_done;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_wv       <= n_wv;
        r_rd_value <= n_rd_value;
        r_used     <= n_used;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
    end

    assign o_done       = r_done;
    assign o_read_value = r_rd_value;
    assign o_read_ok    = r_rd_ok;
    assign o_used_count = USED_W'(r_used);
    assign o_average    = AVG_W'(r_quo);

endmodule

// ===== rtl/ring_buffer_window_average.sv =====
// Top level of the ring buffer with window average: controller plus datapath.
// Depends on rbwa_pkg, rbwa_ctrl, rbwa_dp and rbwa_ram.
//
// Usage: a command word (i_op, i_write_value) is taken at a rising edge where
// start is high and busy is low. Operations are put, push (sliding window),
// get and clear. Each command returns one result word on o_read_value,
// o_read_ok, o_used_count and o_average, shown for exactly one cycle with
// o_done high; the receiver has no way to hold it off.
// Put, push and get: a registered RAM read, an execute step, then a
// bit-serial divider for the average, one quotient bit per cycle over
// 32 + log2(MAX_DEPTH) + 8 bits (50 for the default), after which o_done
// is shown; busy stays high from the accepting edge until then.
// Clear: a sweep that zeroes buffer_size RAM entries, one per cycle, then the
// divider, after which the result is shown.
// Writing i_buffer_size (clamped to 2..MAX_DEPTH) clears the store the same
// way but returns no result. After reset the block sweeps MAX_DEPTH entries
// (1024 by default) with busy high before the first command is taken.
module ring_buffer_window_average import rbwa_pkg::*; #(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_write_value,
    input  logic              i_buffer_size_we,
    input  logic [CFG_W-1:0]  i_buffer_size,
    output logic              o_done,
    output logic [DATA_W-1:0] o_read_value,
    output logic              o_read_ok,
    output logic [USED_W-1:0] o_used_count,
    output logic [AVG_W-1:0]  o_average
);

    t_cmd    cmd;
    t_status status;

    rbwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_cfg_we (i_buffer_size_we),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rbwa_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_op),
        .i_write_value (i_write_value),
        .i_cfg_we      (i_buffer_size_we),
        .i_buffer_size (i_buffer_size),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_read_ok     (o_read_ok),
        .o_used_count  (o_used_count),
        .o_average     (o_average)
    );

endmodule

// ===== rtl/rbwa_chk.sv =====
// Port-level checker for ring_buffer_window_average, attached by bind.
// Depends on rbwa_pkg.
module rbwa_chk import rbwa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [DATA_W-1:0] o_read_value,
    input logic              o_read_ok
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a word was accepted");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_read_ok |-> o_read_value == '0)
        else $error("read value not zero without read data");

endmodule

bind ring_buffer_window_average rbwa_chk u_chk (.*);
